>>> src/energy_silence_endpoint_detector_macros.svh
// Assertion macros for the energy silence endpoint detector.
`ifndef ENERGY_SILENCE_ENDPOINT_DETECTOR_MACROS_SVH
`define ENERGY_SILENCE_ENDPOINT_DETECTOR_MACROS_SVH
`ifndef SYNTH
`define ESED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ESED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ESED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESED_ASSERT(label, prop, msg)
`define ESED_ASSERT_IMP(label, ante, cons, msg)
`define ESED_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> src/esed_pkg.sv
// Shared types and constants of the energy silence endpoint detector.
`default_nettype none
package esed_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQ_W       = 31;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned TMO_W      = 24;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 8'd1;

  localparam logic [THR_W-1:0] THR_RESET   = 31'd2147484;
  localparam logic [TMO_W-1:0] TMO_RESET   = 24'd16000;
  localparam logic [TMO_W-1:0] SILENCE_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            chunk_end;
  } sq_beat_t;

  typedef struct packed {
    logic speech;
    logic stopped;
  } core_status_t;

endpackage
`default_nettype wire

>>> src/esed_if.sv
// Channel interfaces: sample input, chunk result output, register writes.
`default_nettype none
interface esed_in_if;
  import esed_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       chunk_end;
  modport source (output valid, sample, chunk_end, input ready);
  modport sink (input valid, sample, chunk_end, output ready);
endinterface

interface esed_out_if;
  import esed_pkg::*;
  logic             valid;
  logic             ready;
  logic             chunk_loud;
  logic             speech_seen;
  logic [TMO_W-1:0] silence_samples;
  logic             stop;
  modport source (output valid, chunk_loud, speech_seen, silence_samples, stop, input ready);
  modport sink (input valid, chunk_loud, speech_seen, silence_samples, stop, output ready);
endinterface

interface esed_cfg_if;
  import esed_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/energy_silence_endpoint_detector.sv
// Energy silence endpoint detector: top level.
//
// in_i carries one signed 16-bit sample per beat plus chunk_end, which marks
// the last sample of a chunk; a chunk also closes on its MAX_CHUNK-th sample.
// Each closed chunk yields one beat on out_o: chunk_loud (sum of squares above
// threshold times sample count), the sticky speech_seen flag, the silent
// sample count since the last loud chunk, and the sticky stop flag.
// cfg_i writes index 0 (energy threshold) or index 1 (silence timeout); other
// indexes are dropped. cfg_i is always ready; write only while idle.
// Throughput: one sample per cycle while out_o takes results. A chunk's
// result passes the input register and the squaring register, then is
// accumulated and decided into the result register.
// When out_o stalls, the result register holds its beat and the two input
// stages keep filling; samples that do not close a chunk keep flowing.
// Reset clears the chunk sums, flags and silence count and reloads register
// defaults. After stop, every sample is accepted and dropped until reset.
`default_nettype none
`include "energy_silence_endpoint_detector_macros.svh"
module energy_silence_endpoint_detector #(
  parameter int unsigned MAX_CHUNK = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  esed_in_if.sink     in_i,
  esed_out_if.source  out_o,
  esed_cfg_if.sink    cfg_i
);
  import esed_pkg::*;

  logic [THR_W-1:0] thr_q, thr_d;
  logic [TMO_W-1:0] tmo_q, tmo_d;
  logic             sq_valid, sq_ready;
  sq_beat_t         sq_beat;
  core_status_t     status;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    thr_d = thr_q;
    tmo_d = tmo_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IDX_THRESHOLD: thr_d = cfg_i.data[THR_W-1:0];
        CFG_IDX_TIMEOUT:   tmo_d = cfg_i.data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      tmo_q <= TMO_RESET;
    end else begin
      thr_q <= thr_d;
      tmo_q <= tmo_d;
    end
  end

  esed_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_sample_i    (in_i.sample),
    .in_chunk_end_i (in_i.chunk_end),
    .in_ready_o     (in_i.ready),
    .sq_valid_o     (sq_valid),
    .sq_o           (sq_beat),
    .sq_ready_i     (sq_ready)
  );

  esed_core #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sq_valid_i    (sq_valid),
    .sq_i          (sq_beat),
    .sq_ready_o    (sq_ready),
    .thr_i         (thr_q),
    .tmo_i         (tmo_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_loud_o    (out_o.chunk_loud),
    .out_speech_o  (out_o.speech_seen),
    .out_silence_o (out_o.silence_samples),
    .out_stop_o    (out_o.stop),
    .status_o      (status)
  );

  `ESED_ASSERT_NEXT(a_stop_sticky, status.stopped, status.stopped, "stop flag dropped")
  `ESED_ASSERT_NEXT(a_speech_sticky, status.speech, status.speech, "speech flag dropped")
  `ESED_ASSERT(a_stop_needs_speech, !status.stopped || status.speech, "stop without speech")
  `ESED_ASSERT_IMP(a_loud_beat, out_o.valid && out_o.chunk_loud, out_o.speech_seen && (out_o.silence_samples == '0) && !out_o.stop, "loud beat fields inconsistent")

endmodule
`default_nettype wire

>>> src/esed_front.sv
// Input register and squaring stage.
`default_nettype none
module esed_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic signed [esed_pkg::SAMPLE_W-1:0] in_sample_i,
  input  wire logic                                in_chunk_end_i,
  output logic                                     in_ready_o,
  output logic                                     sq_valid_o,
  output esed_pkg::sq_beat_t                       sq_o,
  input  wire logic                                sq_ready_i
);
  import esed_pkg::*;

  logic                       s1_v_q, s1_v_d;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_end_q;
  logic                       s2_v_q, s2_v_d;
  sq_beat_t                   s2_q, s2_d;
  logic                       s1_ready, s2_ready;
  logic [SAMPLE_W:0]          ext;
  logic [SAMPLE_W-1:0]        mag;
  logic [2*SAMPLE_W-1:0]      prod;

  assign s2_ready   = !s2_v_q || sq_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    ext  = {s1_sample_q[SAMPLE_W-1], s1_sample_q};
    mag  = s1_sample_q[SAMPLE_W-1] ? SAMPLE_W'(~ext + 1'b1) : SAMPLE_W'(ext);
    prod = mag * mag;
    s2_d.sq        = prod[SQ_W-1:0];
    s2_d.chunk_end = s1_end_q;
    s1_v_d = s1_ready ? in_valid_i : s1_v_q;
    s2_v_d = s2_ready ? s1_v_q : s2_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_sample_q <= in_sample_i;
      s1_end_q    <= in_chunk_end_i;
    end
    if (s1_v_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign sq_valid_o = s2_v_q;
  assign sq_o       = s2_q;

endmodule
`default_nettype wire

>>> src/esed_core.sv
// Chunk accumulation, loudness decision, silence tracking and result register.
`default_nettype none
module esed_core #(
  parameter int unsigned MAX_CHUNK = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          sq_valid_i,
  input  wire esed_pkg::sq_beat_t            sq_i,
  output logic                               sq_ready_o,
  input  wire logic [esed_pkg::THR_W-1:0]    thr_i,
  input  wire logic [esed_pkg::TMO_W-1:0]    tmo_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_loud_o,
  output logic                               out_speech_o,
  output logic [esed_pkg::TMO_W-1:0]         out_silence_o,
  output logic                               out_stop_o,
  output esed_pkg::core_status_t             status_o
);
  import esed_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNK + 1);
  localparam int unsigned DW = THR_W + CW + 1;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_CHUNK);

  // diff = energy sum minus threshold sum of the current chunk, two's complement
  logic [DW-1:0]    diff_q, diff_d, diff_sum;
  logic [CW-1:0]    count_q, count_d, n;
  logic             speech_q, speech_d;
  logic [TMO_W-1:0] sil_q, sil_d;
  logic             stopped_q, stopped_d;
  logic [TMO_W:0]   sil_sum;
  logic             out_v_q, out_v_d;
  logic             loud_q, loud;
  logic             res_speech_q, res_stop_q;
  logic [TMO_W-1:0] res_sil_q;
  logic             chunk_done, out_free, take, emit;

  always_comb begin
    n          = count_q + 1'b1;
    chunk_done = sq_i.chunk_end || (n == MAX_N);
    out_free   = !out_v_q || out_ready_i;
    sq_ready_o = stopped_q || !chunk_done || out_free;
    take       = sq_valid_i && sq_ready_o && !stopped_q;
    emit       = take && chunk_done;
    diff_sum   = diff_q + DW'(sq_i.sq) - DW'(thr_i);
    loud       = !diff_sum[DW-1] && (diff_sum != '0);
    sil_sum    = {1'b0, sil_q} + (TMO_W+1)'(n);

    diff_d    = diff_q;
    count_d   = count_q;
    speech_d  = speech_q;
    sil_d     = sil_q;
    stopped_d = stopped_q;
    if (take) begin
      if (chunk_done) begin
        diff_d  = '0;
        count_d = '0;
        if (loud) begin
          speech_d = 1'b1;
          sil_d    = '0;
        end else if (speech_q) begin
          sil_d     = sil_sum[TMO_W] ? SILENCE_MAX : sil_sum[TMO_W-1:0];
          stopped_d = (sil_d >= tmo_i);
        end
      end else begin
        diff_d  = diff_sum;
        count_d = n;
      end
    end

    if (emit) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q    <= '0;
      count_q   <= '0;
      speech_q  <= 1'b0;
      sil_q     <= '0;
      stopped_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      diff_q    <= diff_d;
      count_q   <= count_d;
      speech_q  <= speech_d;
      sil_q     <= sil_d;
      stopped_q <= stopped_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      loud_q       <= loud;
      res_speech_q <= speech_d;
      res_sil_q    <= sil_d;
      res_stop_q   <= stopped_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_loud_o    = loud_q;
  assign out_speech_o  = res_speech_q;
  assign out_silence_o = res_sil_q;
  assign out_stop_o    = res_stop_q;
  assign status_o      = '{speech: speech_q, stopped: stopped_q};

endmodule
`default_nettype wire
